// ===== src/rswa_pkg.sv =====
// Package: shared widths, constants and types for the ranged sample window average block.
`timescale 1ns / 1ps
`default_nettype none
package rswa_pkg;

  localparam int WINDOW    = 10;
  localparam int SAMPLE_W  = 16;
  localparam int POS_W     = 4;
  localparam int TALLY_W   = 4;
  localparam int SUM_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID = 2'd1;

  localparam logic [SAMPLE_W-1:0] MIN_VALID_RST = 16'd400;
  localparam logic [SAMPLE_W-1:0] MAX_VALID_RST = 16'd8000;

  localparam logic [POS_W-1:0]     WINDOW_LAST = POS_W'(WINDOW);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = DIV_CNT_W'(SUM_W);

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [TALLY_W-1:0]   divisor;
  } div_req_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [SUM_W-1:0]     quotient;
  } div_sts_t;

endpackage
`default_nettype wire

// ===== src/rswa_if.sv =====
// Interfaces: sample input channel and average result channel.
`timescale 1ns / 1ps
`default_nettype none
interface rswa_in_if;
  logic                          valid;
  logic                          ready;
  logic [rswa_pkg::SAMPLE_W-1:0] sample_mm;

  modport source (output valid, output sample_mm, input ready);
  modport sink   (input valid, input sample_mm, output ready);
endinterface

interface rswa_out_if;
  logic                          valid;
  logic                          ready;
  logic [rswa_pkg::SAMPLE_W-1:0] average_mm;
  logic [rswa_pkg::TALLY_W-1:0]  valid_used;

  modport source (output valid, output average_mm, output valid_used, input ready);
  modport sink   (input valid, input average_mm, input valid_used, output ready);
endinterface
`default_nettype wire

// ===== src/rswa_div.sv =====
// Serial restoring divider: one quotient bit per cycle, shared compare and subtract.
`timescale 1ns / 1ps
`default_nettype none
module rswa_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rswa_pkg::div_req_t req,
  output rswa_pkg::div_sts_t      sts
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [rswa_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rswa_pkg::SUM_W-1:0]       quo_r, quo_nxt;
  logic [rswa_pkg::TALLY_W-1:0]     rem_r, rem_nxt;
  logic [rswa_pkg::TALLY_W-1:0]     dvs_r, dvs_nxt;
  logic [rswa_pkg::TALLY_W:0]       trial;
  logic [rswa_pkg::TALLY_W:0]       diff;
  logic                             fits;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial = {rem_r, quo_r[rswa_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[rswa_pkg::SUM_W-2:0], fits};
      // remainder stays below the divisor, so the low bits hold it
      rem_nxt = fits ? diff[rswa_pkg::TALLY_W-1:0] : trial[rswa_pkg::TALLY_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rswa_pkg::DIV_STEPS - 1'b1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule
`default_nettype wire

// ===== src/ranged_sample_window_average_core.sv =====
// Top level: range-gated window accumulator with a serial divider for the average.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   in_chan  : one 16-bit range sample (mm) per word, valid/ready handshake.
//   out_chan : one result word per closed window with average_mm and valid_used.
//   cfg_*    : write port; index 0 is the low limit, index 1 the high limit.
//              Write only while the block is idle; other indexes are dropped.
// A sample strictly between the limits adds to the window sum and tally.
// Each window spans WINDOW samples; the sample after them closes the window
// and is dropped. Ordinary samples leave the state idle, so ready stays high.
// A closing sample with at least one valid sample starts the serial divider,
// which takes one quotient bit per cycle; the hand-off then passes through the
// done flag and then the hold state, and ready stays low until hold is left.
// The result then moves into the output register once that register is free.
// A stalled receiver does not block intake: ordinary samples keep flowing while
// the result waits; only a second division result waits in the hold state, with
// ready low, until the output register frees.
// Reset (rst_n low, synchronous) restores the limits to 400 and 8000 mm,
// clears sum, tally and window position, and empties the output register.
module ranged_sample_window_average_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rswa_in_if.sink                             in_chan,
  rswa_out_if.source                          out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [rswa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rswa_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [rswa_pkg::SAMPLE_W-1:0]   min_r, max_r;
  logic [rswa_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [rswa_pkg::TALLY_W-1:0]    tally_r, tally_nxt;
  logic [rswa_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [rswa_pkg::TALLY_W-1:0]    used_r, used_nxt;
  logic                            ovld_r, ovld_nxt;
  logic [rswa_pkg::SAMPLE_W-1:0]   oavg_r, oavg_nxt;
  logic [rswa_pkg::TALLY_W-1:0]    oused_r, oused_nxt;

  logic                            in_fire;
  logic                            out_fire;
  logic                            out_free;
  logic                            in_range;
  rswa_pkg::div_req_t              div_req;
  rswa_pkg::div_sts_t              div_sts;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = ovld_r && out_chan.ready;
  assign out_free      = !ovld_r || out_chan.ready;
  assign in_range      = (in_chan.sample_mm > min_r) && (in_chan.sample_mm < max_r);

  rswa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    pos_nxt   = pos_r;
    used_nxt  = used_r;
    ovld_nxt  = ovld_r;
    oavg_nxt  = oavg_r;
    oused_nxt = oused_r;

    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    div_req.divisor  = tally_r;

    // drain the output register
    if (out_fire) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (pos_r < rswa_pkg::WINDOW_LAST) begin
            // advance the window and gate the sample on the limits
            pos_nxt = pos_r + 1'b1;
            if (in_range) begin
              sum_nxt   = sum_r + rswa_pkg::SUM_W'(in_chan.sample_mm);
              tally_nxt = tally_r + 1'b1;
            end
          end else begin
            // closing sample: drop it and divide if anything was collected
            pos_nxt = '0;
            if (tally_r != '0) begin
              div_req.start = 1'b1;
              used_nxt      = tally_r;
              sum_nxt       = '0;
              tally_nxt     = '0;
              state_nxt     = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // hold the quotient until the output register frees
        if (out_free) begin
          ovld_nxt  = 1'b1;
          oavg_nxt  = div_sts.quotient[rswa_pkg::SAMPLE_W-1:0];
          oused_nxt = used_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      tally_r <= '0;
      pos_r   <= '0;
      ovld_r  <= 1'b0;
      min_r   <= rswa_pkg::MIN_VALID_RST;
      max_r   <= rswa_pkg::MAX_VALID_RST;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      tally_r <= tally_nxt;
      pos_r   <= pos_nxt;
      ovld_r  <= ovld_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          rswa_pkg::REG_MIN_VALID: min_r <= cfg_data;
          rswa_pkg::REG_MAX_VALID: max_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    used_r  <= used_nxt;
    oavg_r  <= oavg_nxt;
    oused_r <= oused_nxt;
  end

  assign out_chan.valid      = ovld_r;
  assign out_chan.average_mm = oavg_r;
  assign out_chan.valid_used = oused_r;

endmodule
`default_nettype wire
